@@ hdl/tcci_pkg.sv @@
// Shared types and constants for the two-charge Coulomb integrator.
// No dependencies; every other file of the block imports this package.
package tcci_pkg;

	localparam int FRACTION_BITS_DEF = 16;
	localparam int VAL_W = 24;
	localparam int REG_W = 23;
	localparam int DT_W = 16;
	localparam int DATA_W = 64;
	localparam int MUL_B_W = 32;
	localparam int ADDR_W = 5;
	localparam int PDATA_W = 32;

	typedef enum logic [1:0] {
		CMD_TICK        = 2'd0,
		CMD_RESTORE     = 2'd1,
		CMD_FLIP_FIRST  = 2'd2,
		CMD_FLIP_SECOND = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_MASS_FIRST  = 3'd0,
		REG_MASS_SECOND = 3'd1,
		REG_COUPLING    = 3'd2,
		REG_SOFTENING   = 3'd3,
		REG_BOX         = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]      cmd;
		logic [DT_W-1:0] time_step;
	} in_word_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] first_x;
		logic signed [VAL_W-1:0] first_y;
		logic signed [VAL_W-1:0] first_z;
		logic signed [VAL_W-1:0] second_x;
		logic signed [VAL_W-1:0] second_y;
		logic signed [VAL_W-1:0] second_z;
		logic                    first_positive;
		logic                    second_positive;
	} out_word_t;

	// Request to one of the serial arithmetic units.
	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
	} unit_req_t;

	// Answer of a serial arithmetic unit; result is valid while done is high.
	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] result;
	} unit_rsp_t;

endpackage

@@ hdl/tcci_mul.sv @@
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on tcci_pkg. Product is a times the unsigned low MUL_B_W bits of b, modulo 2^64.
module tcci_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  tcci_pkg::unit_req_t req,
	output tcci_pkg::unit_rsp_t rsp
);
	import tcci_pkg::*;

	localparam int CNT_W = $clog2(MUL_B_W + 1);

	logic [DATA_W-1:0]  a_q;
	logic [DATA_W-1:0]  acc_q;
	logic [MUL_B_W-1:0] b_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MUL_B_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b[MUL_B_W-1:0];
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = acc_q;

endmodule

@@ hdl/tcci_sqrt.sv @@
// Digit-by-digit integer square root, one root bit (two radicand bits) per cycle.
// Depends on tcci_pkg. Result is floor(sqrt(a)) for an unsigned 64-bit a.
module tcci_sqrt (
	input  logic                clk,
	input  logic                arst_n,
	input  tcci_pkg::unit_req_t req,
	output tcci_pkg::unit_rsp_t rsp
);
	import tcci_pkg::*;

	localparam int STEPS = DATA_W / 2;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [DATA_W-1:0] x_q;
	logic [DATA_W-1:0] res_q;
	logic [DATA_W-1:0] bit_q;
	logic [DATA_W-1:0] trial;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q   <= req.a;
			res_q <= '0;
			bit_q <= {2'b01, {(DATA_W-2){1'b0}}};
		end else if (busy_q) begin
			if (x_q >= trial) begin
				x_q   <= x_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = res_q;

endmodule

@@ hdl/tcci_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned 64 by 64 bits.
// Depends on tcci_pkg. Divisor must be nonzero; the quotient is truncated.
module tcci_div (
	input  logic                clk,
	input  logic                arst_n,
	input  tcci_pkg::unit_req_t req,
	output tcci_pkg::unit_rsp_t rsp
);
	import tcci_pkg::*;

	localparam int CNT_W = $clog2(DATA_W + 1);

	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] den_q;
	logic [DATA_W:0]   trial;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	assign trial = {rem_q, quo_q[DATA_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.a;
			den_q <= req.b;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= DATA_W'(trial - {1'b0, den_q});
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = quo_q;

endmodule

@@ hdl/two_charge_coulomb_integrator.sv @@
// Top level of the two-charge softened Coulomb integrator.
// Depends on tcci_pkg, tcci_mul, tcci_sqrt and tcci_div.
//
//   port group  direction  handshake          word
//   in          into block in_valid/in_stall   in_word  (cmd, time_step)
//   out         from block out_valid/out_stall out_word (positions, signs)
//   config      into block APB psel/penable    pwdata/prdata, pready tied high
//
// A tick runs nineteen multiplications, seven divisions and one square root one
// after another, since one serial multiplier, divider and root unit are shared.
// Restore and flip commands go from idle straight to the output state. After reset
// the block is idle and takes a word at once. in_stall is high while a command is
// being worked on; a result that is stalled on the output holds the sequencer until
// it is taken.
module two_charge_coulomb_integrator #(
	parameter int FRACTION_BITS = tcci_pkg::FRACTION_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  tcci_pkg::in_word_t               in_word,
	output logic                             out_valid,
	input  logic                             out_stall,
	output tcci_pkg::out_word_t              out_word,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tcci_pkg::ADDR_W-1:0]      paddr,
	input  logic [tcci_pkg::PDATA_W-1:0]     pwdata,
	output logic [tcci_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready
);
	import tcci_pkg::*;

	// Fixed-point reset constants, rounded to the nearest step.
	localparam longint ONE     = longint'(1) << FRACTION_BITS;
	localparam longint X0      = (18 * ONE + 5) / 10;
	localparam longint Y0      = (6 * ONE + 5) / 10;
	localparam longint V0      = ONE / 4;
	localparam longint MASS_RST = ONE;
	localparam longint K_RST    = (9 * ONE) / 2;
	localparam longint EPS_RST  = (ONE + 5) / 10;
	localparam longint BOX_RST  = (9 * ONE) / 2;
	localparam longint GAIN_CAP = 64'h7FFF_FFFF;
	localparam int     G_W      = 31;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQSUM,
		ST_SQRT,
		ST_CUBE,
		ST_GAIN,
		ST_FORCE,
		ST_IMPULSE,
		ST_DVDIV,
		ST_DRIFT,
		ST_OUT
	} state_t;

	function automatic logic signed [VAL_W-1:0] sat24(input logic signed [DATA_W-1:0] v);
		logic signed [DATA_W-1:0] hi;
		logic signed [DATA_W-1:0] lo;
		hi = DATA_W'((longint'(1) << (VAL_W - 1)) - 1);
		lo = -(DATA_W'(longint'(1) << (VAL_W - 1)));
		if (v > hi) begin
			return VAL_W'(hi);
		end
		if (v < lo) begin
			return VAL_W'(lo);
		end
		return VAL_W'(v);
	endfunction

	// Configuration registers.
	logic [REG_W-1:0] mass_q [2];
	logic [REG_W-1:0] k_q;
	logic [REG_W-1:0] eps_q;
	logic [REG_W-1:0] box_q;
	logic             cfg_write;
	logic [2:0]       cfg_idx;

	// Charge state: index 0 is the first charge, 1 the second.
	logic signed [VAL_W-1:0] pos_q [2][3];
	logic signed [VAL_W-1:0] vel_q [2][3];
	logic                    sign_q [2];

	// Working registers of a tick.
	state_t                   state_q;
	logic                     wait_q;
	logic                     chg_q;
	logic [1:0]               idx_q;
	logic [DT_W-1:0]          dt_q;
	logic signed [VAL_W:0]    r_q [3];
	logic signed [DATA_W-1:0] f_q [3];
	logic [DATA_W-1:0]        sum_q;
	logic [DATA_W-1:0]        d2_q;
	logic [DATA_W-1:0]        s_q;
	logic [DATA_W-1:0]        d3_q;
	logic [G_W-1:0]           g_q;
	logic signed [DATA_W-1:0] num_q;
	logic                     out_valid_q;
	out_word_t                out_word_q;

	// Arithmetic units and their requests.
	unit_req_t mul_req;
	unit_req_t sqrt_req;
	unit_req_t div_req;
	unit_rsp_t mul_rsp;
	unit_rsp_t sqrt_rsp;
	unit_rsp_t div_rsp;

	logic signed [VAL_W:0]    r_sel;
	logic [VAL_W:0]           r_abs;
	logic signed [DATA_W-1:0] f_sel;
	logic [DATA_W-1:0]        num_abs;
	logic [DATA_W-1:0]        sum_next;
	logic signed [DATA_W-1:0] mul_shift_f;
	logic signed [DATA_W-1:0] mul_shift_dt;
	logic signed [DATA_W-1:0] dv;
	logic signed [DATA_W-1:0] p_new;
	logic signed [DATA_W-1:0] box_pos;
	logic [DATA_W-1:0]        d3_raw;
	logic [REG_W-1:0]         mass_sel;
	logic                     in_accept;
	logic                     out_free;

	tcci_mul  u_mul  (.clk(clk), .arst_n(arst_n), .req(mul_req),  .rsp(mul_rsp));
	tcci_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .req(sqrt_req), .rsp(sqrt_rsp));
	tcci_div  u_div  (.clk(clk), .arst_n(arst_n), .req(div_req),  .rsp(div_rsp));

	// Configuration port. Writes land on the access cycle; reads are plain muxing.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign cfg_idx   = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q[0] <= REG_W'(MASS_RST);
			mass_q[1] <= REG_W'(MASS_RST);
			k_q       <= REG_W'(K_RST);
			eps_q     <= REG_W'(EPS_RST);
			box_q     <= REG_W'(BOX_RST);
		end else if (cfg_write) begin
			case (cfg_idx)
				REG_MASS_FIRST:  mass_q[0] <= pwdata[REG_W-1:0];
				REG_MASS_SECOND: mass_q[1] <= pwdata[REG_W-1:0];
				REG_COUPLING:    k_q       <= pwdata[REG_W-1:0];
				REG_SOFTENING:   eps_q     <= pwdata[REG_W-1:0];
				REG_BOX:         box_q     <= pwdata[REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_MASS_FIRST:  prdata = PDATA_W'(mass_q[0]);
			REG_MASS_SECOND: prdata = PDATA_W'(mass_q[1]);
			REG_COUPLING:    prdata = PDATA_W'(k_q);
			REG_SOFTENING:   prdata = PDATA_W'(eps_q);
			REG_BOX:         prdata = PDATA_W'(box_q);
			default:         prdata = '0;
		endcase
	end

	// Handshakes. A new word is taken only while the sequencer is idle.
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// Operand selection for the shared units.
	assign r_sel    = r_q[idx_q];
	assign r_abs    = r_sel[VAL_W] ? (VAL_W + 1)'(-r_sel) : r_sel;
	assign f_sel    = chg_q ? -f_q[idx_q] : f_q[idx_q];
	assign num_abs  = num_q[DATA_W-1] ? -num_q : num_q;
	assign mass_sel = (mass_q[chg_q] == '0) ? REG_W'(1) : mass_q[chg_q];

	// Result shaping after each unit finishes.
	assign sum_next     = sum_q + mul_rsp.result;
	assign mul_shift_f  = $signed(mul_rsp.result) >>> FRACTION_BITS;
	assign mul_shift_dt = $signed(mul_rsp.result) >>> DT_W;
	assign d3_raw       = mul_rsp.result >> FRACTION_BITS;
	assign dv           = num_q[DATA_W-1] ? -$signed(div_rsp.result) : $signed(div_rsp.result);
	assign p_new        = DATA_W'(pos_q[chg_q][idx_q]) + mul_shift_dt;
	assign box_pos      = $signed(DATA_W'(box_q));

	always_comb begin
		mul_req  = '0;
		sqrt_req = '0;
		div_req  = '0;
		case (state_q)
			ST_SQSUM: begin
				// The square is taken on the magnitude so it never goes negative.
				mul_req.start = !wait_q;
				mul_req.a     = DATA_W'(r_abs);
				mul_req.b     = DATA_W'(r_abs);
			end
			ST_SQRT: begin
				sqrt_req.start = !wait_q;
				sqrt_req.a     = d2_q << FRACTION_BITS;
			end
			ST_CUBE: begin
				mul_req.start = !wait_q;
				mul_req.a     = d2_q;
				mul_req.b     = s_q;
			end
			ST_GAIN: begin
				div_req.start = !wait_q;
				div_req.a     = DATA_W'(k_q) << FRACTION_BITS;
				div_req.b     = d3_q;
			end
			ST_FORCE: begin
				mul_req.start = !wait_q;
				mul_req.a     = DATA_W'(r_sel);
				mul_req.b     = DATA_W'(g_q);
			end
			ST_IMPULSE: begin
				mul_req.start = !wait_q;
				mul_req.a     = f_sel;
				mul_req.b     = DATA_W'(dt_q);
			end
			ST_DVDIV: begin
				div_req.start = !wait_q;
				div_req.a     = num_abs;
				div_req.b     = DATA_W'(mass_sel);
			end
			ST_DRIFT: begin
				mul_req.start = !wait_q;
				mul_req.a     = DATA_W'(vel_q[chg_q][idx_q]);
				mul_req.b     = DATA_W'(dt_q);
			end
			default: ;
		endcase
	end

	// Sequencer. Each arithmetic state launches its unit once per operation, then waits for done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wait_q      <= 1'b0;
			chg_q       <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			pos_q[0][0] <= VAL_W'(-X0);
			pos_q[0][1] <= VAL_W'(Y0);
			pos_q[0][2] <= '0;
			pos_q[1][0] <= VAL_W'(X0);
			pos_q[1][1] <= VAL_W'(Y0);
			pos_q[1][2] <= '0;
			vel_q[0][0] <= '0;
			vel_q[0][1] <= '0;
			vel_q[0][2] <= VAL_W'(V0);
			vel_q[1][0] <= '0;
			vel_q[1][1] <= '0;
			vel_q[1][2] <= VAL_W'(-V0);
			sign_q[0]   <= 1'b1;
			sign_q[1]   <= 1'b0;
		end else begin
			// The output state loads the next word itself when the old one leaves.
			if (out_valid_q && !out_stall && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			if (mul_req.start || sqrt_req.start || div_req.start) begin
				wait_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						dt_q  <= in_word.time_step;
						idx_q <= '0;
						chg_q <= 1'b0;
						sum_q <= '0;
						case (in_word.cmd)
							CMD_TICK: begin
								r_q[0]  <= (VAL_W + 1)'(pos_q[1][0]) - (VAL_W + 1)'(pos_q[0][0]);
								r_q[1]  <= (VAL_W + 1)'(pos_q[1][1]) - (VAL_W + 1)'(pos_q[0][1]);
								r_q[2]  <= (VAL_W + 1)'(pos_q[1][2]) - (VAL_W + 1)'(pos_q[0][2]);
								state_q <= ST_SQSUM;
							end
							CMD_RESTORE: begin
								pos_q[0][0] <= VAL_W'(-X0);
								pos_q[0][1] <= VAL_W'(Y0);
								pos_q[0][2] <= '0;
								pos_q[1][0] <= VAL_W'(X0);
								pos_q[1][1] <= VAL_W'(Y0);
								pos_q[1][2] <= '0;
								vel_q[0][0] <= '0;
								vel_q[0][1] <= '0;
								vel_q[0][2] <= VAL_W'(V0);
								vel_q[1][0] <= '0;
								vel_q[1][1] <= '0;
								vel_q[1][2] <= VAL_W'(-V0);
								sign_q[0]   <= 1'b1;
								sign_q[1]   <= 1'b0;
								state_q     <= ST_OUT;
							end
							CMD_FLIP_FIRST: begin
								sign_q[0] <= !sign_q[0];
								state_q   <= ST_OUT;
							end
							default: begin
								sign_q[1] <= !sign_q[1];
								state_q   <= ST_OUT;
							end
						endcase
					end
				end
				ST_SQSUM: begin
					if (mul_rsp.done) begin
						wait_q <= 1'b0;
						sum_q  <= sum_next;
						if (idx_q == 2'd2) begin
							d2_q    <= (sum_next >> FRACTION_BITS) + DATA_W'(eps_q);
							state_q <= ST_SQRT;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_SQRT: begin
					if (sqrt_rsp.done) begin
						wait_q  <= 1'b0;
						s_q     <= sqrt_rsp.result;
						state_q <= ST_CUBE;
					end
				end
				ST_CUBE: begin
					if (mul_rsp.done) begin
						wait_q  <= 1'b0;
						// A zero denominator is taken as the smallest step.
						d3_q    <= (d3_raw == '0) ? DATA_W'(1) : d3_raw;
						state_q <= ST_GAIN;
					end
				end
				ST_GAIN: begin
					if (div_rsp.done) begin
						wait_q  <= 1'b0;
						g_q     <= (div_rsp.result > DATA_W'(GAIN_CAP)) ? G_W'(GAIN_CAP)
						           : div_rsp.result[G_W-1:0];
						idx_q   <= '0;
						state_q <= ST_FORCE;
					end
				end
				ST_FORCE: begin
					if (mul_rsp.done) begin
						wait_q <= 1'b0;
						// Like charges push the first charge away from the second.
						f_q[idx_q] <= (sign_q[0] == sign_q[1]) ? -mul_shift_f : mul_shift_f;
						if (idx_q == 2'd2) begin
							idx_q   <= '0;
							chg_q   <= 1'b0;
							state_q <= ST_IMPULSE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_IMPULSE: begin
					if (mul_rsp.done) begin
						wait_q  <= 1'b0;
						num_q   <= mul_shift_dt <<< FRACTION_BITS;
						state_q <= ST_DVDIV;
					end
				end
				ST_DVDIV: begin
					if (div_rsp.done) begin
						wait_q <= 1'b0;
						vel_q[chg_q][idx_q] <= sat24(DATA_W'(vel_q[chg_q][idx_q]) + dv);
						if (idx_q == 2'd2) begin
							idx_q   <= '0;
							state_q <= ST_DRIFT;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_IMPULSE;
						end
					end
				end
				ST_DRIFT: begin
					if (mul_rsp.done) begin
						wait_q <= 1'b0;
						// y only saturates; x and z are held inside the box.
						if (idx_q == 2'd1) begin
							pos_q[chg_q][idx_q] <= sat24(p_new);
						end else if (p_new > box_pos) begin
							pos_q[chg_q][idx_q] <= VAL_W'(box_pos);
						end else if (p_new < -box_pos) begin
							pos_q[chg_q][idx_q] <= VAL_W'(-box_pos);
						end else begin
							pos_q[chg_q][idx_q] <= VAL_W'(p_new);
						end
						if (idx_q == 2'd2) begin
							idx_q <= '0;
							if (chg_q) begin
								state_q <= ST_OUT;
							end else begin
								chg_q   <= 1'b1;
								state_q <= ST_IMPULSE;
							end
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q                <= 1'b1;
						out_word_q.first_x         <= pos_q[0][0];
						out_word_q.first_y         <= pos_q[0][1];
						out_word_q.first_z         <= pos_q[0][2];
						out_word_q.second_x        <= pos_q[1][0];
						out_word_q.second_y        <= pos_q[1][1];
						out_word_q.second_z        <= pos_q[1][2];
						out_word_q.first_positive  <= sign_q[0];
						out_word_q.second_positive <= sign_q[1];
						state_q                    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ sim/tb.sv @@
// Self-checking bench for two_charge_coulomb_integrator: predicts every result word.
// Depends on tcci_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb;
	import tcci_pkg::*;

	localparam int FB = 16;
	localparam int HOLD_LEN = 3000;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_word_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_word_t out_word;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	two_charge_coulomb_integrator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	// Shadow copy of the block: positions, velocities, charge signs and registers.
	longint pos_a[3], pos_b[3], vel_a[3], vel_b[3];
	bit pos_sign_a, pos_sign_b;
	longint reg_val[5];

	in_word_t cmd_queue[$];
	out_word_t expected_words[$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	bit hold_go = 1'b0;
	bit hold_seen = 1'b0;
	int hold_left = 0;
	int failures = 0;
	int words_checked = 0;
	int ticks_sent = 0;
	int quiet_cycles = 0;

	function automatic longint sat_value(longint v);
		if (v > 64'sd8388607) return 64'sd8388607;
		if (v < -64'sd8388608) return -64'sd8388608;
		return v;
	endfunction

	function automatic longint int_sqrt(longint unsigned x);
		longint unsigned res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > x) bit_v >>= 2;
		while (bit_v != 0) begin
			if (x >= res + bit_v) begin
				x -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else begin
				res >>= 1;
			end
			bit_v >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic void restore_charges();
		pos_a = '{-64'sd117965, 64'sd39322, 64'sd0};
		pos_b = '{64'sd117965, 64'sd39322, 64'sd0};
		vel_a = '{64'sd0, 64'sd0, 64'sd16384};
		vel_b = '{64'sd0, 64'sd0, -64'sd16384};
		pos_sign_a = 1'b1;
		pos_sign_b = 1'b0;
	endfunction

	// Velocity then position update of one charge; x and z clamp to the box.
	function automatic void advance_charge(ref longint p[3], ref longint v[3],
			input longint f[3], input longint mass, input longint dt);
		longint m, box, q;
		m = (mass == 0) ? 1 : mass;
		box = reg_val[REG_BOX];
		for (int i = 0; i < 3; i++)
			v[i] = sat_value(v[i] + (((f[i] * dt) >>> 16) * (64'sd1 <<< FB)) / m);
		for (int i = 0; i < 3; i++) begin
			q = p[i] + ((v[i] * dt) >>> 16);
			if (i == 1) begin
				q = sat_value(q);
			end else begin
				if (q > box) q = box;
				if (q < -box) q = -box;
			end
			p[i] = q;
		end
	endfunction

	function automatic void coulomb_tick(longint dt);
		longint r[3], fa[3], fb[3];
		longint unsigned sum, d2, s, d3, g;
		longint mv;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			r[i] = pos_b[i] - pos_a[i];
			sum += longint'(r[i] * r[i]);
		end
		d2 = (sum >> FB) + reg_val[REG_SOFTENING];
		s = int_sqrt(d2 << FB);
		d3 = (d2 * s) >> FB;
		if (d3 == 0) d3 = 1;
		g = (longint'(reg_val[REG_COUPLING]) << FB) / d3;
		if (g > 64'd2147483647) g = 64'd2147483647;
		for (int i = 0; i < 3; i++) begin
			mv = (r[i] * longint'(g)) >>> FB;
			// Like charges push apart, unlike charges pull together.
			fa[i] = (pos_sign_a == pos_sign_b) ? -mv : mv;
			fb[i] = -fa[i];
		end
		advance_charge(pos_a, vel_a, fa, reg_val[REG_MASS_FIRST], dt);
		advance_charge(pos_b, vel_b, fb, reg_val[REG_MASS_SECOND], dt);
	endfunction

	function automatic out_word_t apply_command(in_word_t w);
		out_word_t o;
		case (cmd_t'(w.cmd))
			CMD_TICK: coulomb_tick(longint'(w.time_step));
			CMD_RESTORE: restore_charges();
			CMD_FLIP_FIRST: pos_sign_a = ~pos_sign_a;
			default: pos_sign_b = ~pos_sign_b;
		endcase
		o.first_x = pos_a[0][23:0];
		o.first_y = pos_a[1][23:0];
		o.first_z = pos_a[2][23:0];
		o.second_x = pos_b[0][23:0];
		o.second_y = pos_b[1][23:0];
		o.second_z = pos_b[2][23:0];
		o.first_positive = pos_sign_a;
		o.second_positive = pos_sign_b;
		return o;
	endfunction

	// Input driver. A word is accepted on an edge with valid high and stall low;
	// it is predicted right there, so the expected word follows the command order.
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			expected_words.insert(expected_words.size(), apply_command(in_word));
			if (in_word.cmd == CMD_TICK) ticks_sent++;
		end
		if (!in_valid || !in_stall) begin
			if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_word <= cmd_queue[0];
				cmd_queue.delete(0);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	task automatic check_field(string name, logic [VAL_W-1:0] e, logic [VAL_W-1:0] a);
		if (e !== a) begin
			$error("%s mismatch: expected %0d, got %0d", name, $signed(e), $signed(a));
			failures++;
		end
	endtask

	// Output monitor and stall generator. A long hold-off can be requested by
	// toggling hold_go; it is counted down here so the block backs up on its input.
	always @(posedge clk) begin
		out_word_t e;
		if (out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				$error("result word arrived with nothing expected");
				failures++;
			end else begin
				e = expected_words[0];
				expected_words.delete(0);
				words_checked++;
				check_field("first_x", e.first_x, out_word.first_x);
				check_field("first_y", e.first_y, out_word.first_y);
				check_field("first_z", e.first_z, out_word.first_z);
				check_field("second_x", e.second_x, out_word.second_x);
				check_field("second_y", e.second_y, out_word.second_y);
				check_field("second_z", e.second_z, out_word.second_z);
				check_field("first_positive", e.first_positive, out_word.first_positive);
				check_field("second_positive", e.second_positive, out_word.second_positive);
			end
		end
		if (hold_go != hold_seen) begin
			hold_seen <= hold_go;
			hold_left <= HOLD_LEN;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Watchdog: any accepted word on either channel or a register write resets it.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("two_charge_coulomb_integrator verification failed");
			$finish;
		end
	end

	// Register write: setup cycle, then access cycle; pready is always high.
	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		reg_val[idx] = longint'(value[REG_W-1:0]);
	endtask

	task automatic push_cmd(cmd_t c, logic [DT_W-1:0] dt);
		in_word_t w;
		w.cmd = c;
		w.time_step = dt;
		cmd_queue.insert(cmd_queue.size(), w);
	endtask

	// Mostly ticks with a realistic frame time, some with any 16-bit value,
	// plus the occasional restore and sign flips.
	task automatic push_random(int n);
		int sel;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(19);
			if (sel < 12)
				push_cmd(CMD_TICK, DT_W'($urandom_range(200, 2200)));
			else if (sel < 15)
				push_cmd(CMD_TICK, DT_W'($urandom));
			else if (sel < 16)
				push_cmd(CMD_RESTORE, DT_W'($urandom));
			else if (sel < 18)
				push_cmd(CMD_FLIP_FIRST, DT_W'($urandom));
			else
				push_cmd(CMD_FLIP_SECOND, DT_W'($urandom));
		end
	endtask

	// Wait for the block to go quiet so registers can be rewritten safely.
	task automatic drain();
		wait (cmd_queue.size() == 0 && !in_valid && expected_words.size() == 0);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		reg_val = '{64'd65536, 64'd65536, 64'd294912, 64'd6554, 64'd294912};
		restore_charges();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening at reset registers: every command, frame time extremes.
		push_cmd(CMD_TICK, 16'd0);
		push_cmd(CMD_TICK, 16'hFFFF);
		push_cmd(CMD_TICK, 16'd1092);
		push_cmd(CMD_FLIP_FIRST, 16'hFFFF);
		push_cmd(CMD_TICK, 16'd1092);
		push_cmd(CMD_FLIP_SECOND, 16'd0);
		push_cmd(CMD_TICK, 16'hFFFF);
		push_cmd(CMD_RESTORE, 16'hA5A5);
		push_cmd(CMD_TICK, 16'd1);
		push_cmd(CMD_TICK, 16'h8000);
		drain();

		// Zero first mass, largest second mass, strongest coupling, no softening.
		write_reg(REG_MASS_FIRST, 32'hFF80_0000);
		write_reg(REG_MASS_SECOND, 32'h007F_FFFF);
		write_reg(REG_COUPLING, 32'h007F_FFFF);
		write_reg(REG_SOFTENING, 32'd0);
		write_reg(REG_BOX, 32'h007F_FFFF);
		push_cmd(CMD_RESTORE, 16'd0);
		push_cmd(CMD_TICK, 16'hFFFF);
		push_random(80);
		drain();

		// A zero box pins x and z to 0, so the charges end up coincident and,
		// without softening, feel no force at all.
		write_reg(REG_BOX, 32'd0);
		push_cmd(CMD_RESTORE, 16'd0);
		push_cmd(CMD_TICK, 16'd1092);
		push_cmd(CMD_TICK, 16'hFFFF);
		push_cmd(CMD_FLIP_FIRST, 16'd0);
		push_cmd(CMD_TICK, 16'd1092);
		send_idle_pct = 50;
		push_random(60);
		drain();

		// Lightest masses and a long output hold-off while input keeps coming.
		write_reg(REG_MASS_FIRST, 32'd1);
		write_reg(REG_MASS_SECOND, 32'd1);
		write_reg(REG_COUPLING, 32'd655);
		write_reg(REG_SOFTENING, 32'd65536);
		write_reg(REG_BOX, 32'd196608);
		send_idle_pct = 0;
		stall_pct = 50;
		push_cmd(CMD_RESTORE, 16'd0);
		push_random(120);
		repeat (200) @(posedge clk);
		hold_go = ~hold_go;
		drain();

		// Back to the reset values, both sides idling a little.
		write_reg(REG_MASS_FIRST, 32'd65536);
		write_reg(REG_MASS_SECOND, 32'd65536);
		write_reg(REG_COUPLING, 32'd294912);
		write_reg(REG_SOFTENING, 32'd6554);
		write_reg(REG_BOX, 32'd294912);
		send_idle_pct = 7;
		stall_pct = 7;
		push_cmd(CMD_RESTORE, 16'd0);
		push_random(120);
		drain();

		// Random register values across the full range, no idling.
		write_reg(REG_MASS_FIRST, $urandom);
		write_reg(REG_MASS_SECOND, $urandom);
		write_reg(REG_COUPLING, $urandom);
		write_reg(REG_SOFTENING, $urandom);
		write_reg(REG_BOX, $urandom);
		send_idle_pct = 0;
		stall_pct = 0;
		push_cmd(CMD_RESTORE, 16'd0);
		push_random(100);
		drain();

		$display("Checked %0d result words, %0d of them after ticks, over six register settings",
			words_checked, ticks_sent);
		$display("including zero mass, zero box, no softening and a long output hold-off.");
		if (failures == 0)
			$display("two_charge_coulomb_integrator verification clean");
		else
			$display("two_charge_coulomb_integrator verification failed");
		$finish;
	end

endmodule
